// File: src/mbe_pkg.sv
package mbe_pkg;

    localparam int WORD_W         = 64;
    localparam int HALF_W         = 32;
    localparam int STEP_W         = 63;
    localparam int LIMIT_W        = 16;
    localparam int BAIL_BITS      = 16;
    localparam int CFG_IDX_W      = 3;

    localparam int FRAC_BITS_DEF  = 44;
    localparam int COORD_BITS_DEF = 13;
    localparam int ITER_BITS_DEF  = 16;

    localparam logic [LIMIT_W-1:0] MAX_ITER_RST = 16'd1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MAPW,
        S_CADD,
        S_ITW,
        S_UPDATE,
        S_ABS,
        S_DONE
    } t_state;

    // which 64x64 product the multiplier is building
    typedef enum logic [2:0] {
        P_CX,
        P_CY,
        P_XX,
        P_YY,
        P_XY
    } t_prod;

    // partial product placement in the 128-bit accumulator
    typedef enum logic [1:0] {
        OFF_0,
        OFF_32,
        OFF_64
    } t_off;

    // fixed-point scaling of the finished product
    typedef enum logic [1:0] {
        SH_NONE,
        SH_FRAC,
        SH_FRAC1
    } t_shr;

    typedef struct packed {
        logic  valid;
        logic  first;
        logic  last;
        t_off  off;
        t_shr  shr;
        t_prod dest;
    } t_mac_cmd;

    typedef struct packed {
        logic  valid;
        t_prod dest;
    } t_mac_res;

endpackage

// File: src/mbe_mac.sv
module mbe_mac #(
    parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mbe_pkg::t_mac_cmd            i_cmd,
    input  logic [mbe_pkg::HALF_W-1:0]   i_a,
    input  logic [mbe_pkg::HALF_W-1:0]   i_b,
    output mbe_pkg::t_mac_res            o_res,
    output logic [mbe_pkg::WORD_W-1:0]   o_res_data
);
    import mbe_pkg::*;

    localparam int ACC_W = 2 * WORD_W;

    t_mac_cmd           r_cmd;
    logic [WORD_W-1:0]  r_pp;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   n_acc;
    logic [ACC_W-1:0]   pp_ext;
    logic [ACC_W-1:0]   scaled;

    // stage 1: one 32x32 partial product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
        end else begin
            r_cmd <= i_cmd;
        end
        r_pp <= i_a * i_b;
        if (r_cmd.valid) begin
            r_acc <= n_acc;
        end
    end

    // stage 2: place and accumulate
    always_comb begin
        case (r_cmd.off)
            OFF_0:   pp_ext = {{WORD_W{1'b0}}, r_pp};
            OFF_32:  pp_ext = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
            OFF_64:  pp_ext = {r_pp, {WORD_W{1'b0}}};
            default: pp_ext = '0;
        endcase
        n_acc = (r_cmd.first ? {ACC_W{1'b0}} : r_acc) + pp_ext;
        case (r_cmd.shr)
            SH_FRAC:  scaled = n_acc >> FRAC_BITS;
            SH_FRAC1: scaled = n_acc >> (FRAC_BITS - 1);
            default:  scaled = n_acc;
        endcase
    end

    // saturate to 64 bits on the last partial product
    assign o_res_data = (|scaled[ACC_W-1:WORD_W]) ? {WORD_W{1'b1}} : scaled[WORD_W-1:0];
    assign o_res.valid = r_cmd.valid & r_cmd.last;
    assign o_res.dest  = r_cmd.dest;

endmodule

// File: src/mbe_core.sv
module mbe_core #(
    parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
    parameter int ITER_BITS  = mbe_pkg::ITER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [COORD_BITS-1:0]               i_col,
    input  logic [COORD_BITS-1:0]               i_row,
    input  logic signed [mbe_pkg::WORD_W-1:0]   i_x_origin,
    input  logic signed [mbe_pkg::WORD_W-1:0]   i_y_origin,
    input  logic [mbe_pkg::STEP_W-1:0]          i_x_step,
    input  logic [mbe_pkg::STEP_W-1:0]          i_y_step,
    input  logic [mbe_pkg::LIMIT_W-1:0]         i_max_iter,
    input  logic                                i_res_ready,
    output logic                                o_ready,
    output logic                                o_res_valid,
    output logic [ITER_BITS-1:0]                o_iterations,
    output logic                                o_escaped,
    output logic [mbe_pkg::WORD_W-1:0]          o_final_mag_sq
);
    import mbe_pkg::*;

    localparam int EXT_W = WORD_W + 2;
    localparam logic [WORD_W-1:0] THR = (BAIL_BITS + FRAC_BITS < WORD_W)
        ? ({{(WORD_W-1){1'b0}}, 1'b1} << (BAIL_BITS + FRAC_BITS))
        : {WORD_W{1'b1}};

    function automatic logic signed [WORD_W-1:0] clamp(input logic signed [EXT_W-1:0] s);
        logic [2:0] top;
        top = s[EXT_W-1:WORD_W-1];
        if ((&top) || !(|top)) begin
            return s[WORD_W-1:0];
        end else if (s[EXT_W-1]) begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

    t_state                    r_state, n_state;
    t_prod                     r_prod, n_prod;
    logic [1:0]                r_k, n_k;

    logic [COORD_BITS-1:0]     r_col, r_row;
    logic [ITER_BITS-1:0]      r_limit, r_iter;
    logic [WORD_W-1:0]         r_tx, r_ty, r_xx, r_yy, r_xy;
    logic signed [WORD_W-1:0]  r_cx, r_cy, r_zx, r_zy;
    logic [WORD_W-1:0]         r_zx_mag, r_zy_mag;
    logic [WORD_W-1:0]         r_mag;
    logic                      r_esc;

    logic [ITER_BITS-1:0]      lim_in;
    logic [WORD_W-1:0]         a64, b64;
    logic [1:0]                last_k;
    logic                      last_pp;
    t_mac_cmd                  mac_cmd;
    t_mac_res                  mac_res;
    logic [WORD_W-1:0]         mac_data;
    logic [HALF_W-1:0]         mac_a, mac_b;

    logic [WORD_W:0]           mag_sum;
    logic [WORD_W-1:0]         mag;
    logic                      stop;
    logic signed [EXT_W-1:0]   xx_e, yy_e, xy_e, cx_e, cy_e, s_t, s_y;
    logic signed [EXT_W-1:0]   tx_e, ty_e, xo_e, yo_e;
    logic                      pneg;

    // limit wider than the count saturates
    assign lim_in = (|(i_max_iter >> ITER_BITS)) ? {ITER_BITS{1'b1}}
                                                  : i_max_iter[ITER_BITS-1:0];

    // operand selection for the shared multiplier
    always_comb begin
        case (r_prod)
            P_CX:    begin a64 = WORD_W'(r_col);  b64 = {1'b0, i_x_step}; end
            P_CY:    begin a64 = WORD_W'(r_row);  b64 = {1'b0, i_y_step}; end
            P_XX:    begin a64 = r_zx_mag;        b64 = r_zx_mag;         end
            P_YY:    begin a64 = r_zy_mag;        b64 = r_zy_mag;         end
            P_XY:    begin a64 = r_zx_mag;        b64 = r_zy_mag;         end
            default: begin a64 = '0;              b64 = '0;               end
        endcase
    end

    assign mac_a   = r_k[1] ? a64[WORD_W-1:HALF_W] : a64[HALF_W-1:0];
    assign mac_b   = r_k[0] ? b64[WORD_W-1:HALF_W] : b64[HALF_W-1:0];
    assign last_k  = (r_prod == P_CX || r_prod == P_CY) ? 2'd1 : 2'd3;
    assign last_pp = (r_k == last_k);

    always_comb begin
        mac_cmd.valid = (r_state == S_MUL);
        mac_cmd.first = (r_k == 2'd0);
        mac_cmd.last  = last_pp;
        mac_cmd.dest  = r_prod;
        if (r_k == 2'd0) begin
            mac_cmd.off = OFF_0;
        end else if (r_k == 2'd3) begin
            mac_cmd.off = OFF_64;
        end else begin
            mac_cmd.off = OFF_32;
        end
        case (r_prod) inside
            P_XX, P_YY: mac_cmd.shr = SH_FRAC;
            P_XY:       mac_cmd.shr = SH_FRAC1;
            default:    mac_cmd.shr = SH_NONE;
        endcase
    end

    mbe_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (mac_cmd),
        .i_a        (mac_a),
        .i_b        (mac_b),
        .o_res      (mac_res),
        .o_res_data (mac_data)
    );

    // bailout test and next z
    assign mag_sum = {1'b0, r_xx} + {1'b0, r_yy};
    assign mag     = mag_sum[WORD_W] ? {WORD_W{1'b1}} : mag_sum[WORD_W-1:0];
    assign stop    = (mag >= THR) || (r_iter >= r_limit);

    assign xx_e = $signed({2'b00, r_xx});
    assign yy_e = $signed({2'b00, r_yy});
    assign xy_e = $signed({2'b00, r_xy});
    assign cx_e = $signed({{2{r_cx[WORD_W-1]}}, r_cx});
    assign cy_e = $signed({{2{r_cy[WORD_W-1]}}, r_cy});
    assign pneg = r_zx[WORD_W-1] ^ r_zy[WORD_W-1];
    assign s_t  = xx_e - yy_e + cx_e;
    assign s_y  = pneg ? (cy_e - xy_e) : (cy_e + xy_e);

    // pixel to c
    assign tx_e = $signed({2'b00, r_tx});
    assign ty_e = $signed({2'b00, r_ty});
    assign xo_e = $signed({{2{i_x_origin[WORD_W-1]}}, i_x_origin});
    assign yo_e = $signed({{2{i_y_origin[WORD_W-1]}}, i_y_origin});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prod  <= P_CX;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_prod  <= n_prod;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL;
                    n_prod  = P_CX;
                    n_k     = '0;
                end
            end
            S_MUL: begin
                if (last_pp) begin
                    n_k = '0;
                    case (r_prod)
                        P_CX:    n_prod  = P_CY;
                        P_CY:    n_state = S_MAPW;
                        P_XX:    n_prod  = P_YY;
                        P_YY:    n_prod  = P_XY;
                        P_XY:    n_state = S_ITW;
                        default: n_state = S_IDLE;
                    endcase
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_MAPW:   n_state = S_CADD;
            S_CADD: begin
                n_state = S_MUL;
                n_prod  = P_XX;
                n_k     = '0;
            end
            S_ITW:    n_state = S_UPDATE;
            S_UPDATE: n_state = stop ? S_DONE : S_ABS;
            S_ABS: begin
                n_state = S_MUL;
                n_prod  = P_XX;
                n_k     = '0;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_col    <= i_col;
            r_row    <= i_row;
            r_limit  <= lim_in;
            r_iter   <= '0;
            r_zx     <= '0;
            r_zy     <= '0;
            r_zx_mag <= '0;
            r_zy_mag <= '0;
        end
        if (mac_res.valid) begin
            case (mac_res.dest)
                P_CX:    r_tx <= mac_data;
                P_CY:    r_ty <= mac_data;
                P_XX:    r_xx <= mac_data;
                P_YY:    r_yy <= mac_data;
                default: r_xy <= mac_data;
            endcase
        end
        if (r_state == S_CADD) begin
            r_cx <= clamp(xo_e + tx_e);
            r_cy <= clamp(yo_e + ty_e);
        end
        if (r_state == S_UPDATE) begin
            if (stop) begin
                r_mag <= mag;
                r_esc <= (r_iter < r_limit);
            end else begin
                r_zx   <= clamp(s_t);
                r_zy   <= clamp(s_y);
                r_iter <= r_iter + ITER_BITS'(1);
            end
        end
        if (r_state == S_ABS) begin
            r_zx_mag <= r_zx[WORD_W-1] ? $unsigned(-r_zx) : $unsigned(r_zx);
            r_zy_mag <= r_zy[WORD_W-1] ? $unsigned(-r_zy) : $unsigned(r_zy);
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_DONE);
    assign o_iterations   = r_iter;
    assign o_escaped      = r_esc;
    assign o_final_mag_sq = r_mag;

endmodule

// File: src/mandelbrot_escape_time.sv
// mandelbrot escape-time unit: each transfer on the slave stream carries one pixel (col, row),
// mapped to c = (x_origin + col*x_step) + i*(y_origin + row*y_step) in signed fixed point with
// FRAC_BITS fraction bits; from z = 0 the unit iterates z = z*z + c until |z|^2 reaches
// 65536 or the iteration limit is hit, and returns one result per pixel carrying the count,
// an escaped flag (clear when the limit was reached, also when bailout lands on it) and the
// final |z|^2, saturated at the top of 64 bits. all products run on a single 32x32 multiplier
// with a 128-bit accumulator, four partial products per 64x64 product of z (two for each
// pixel mapping product) and three products per iteration. the default iteration limit is
// 1024. one pixel is worked on at a time and s_axis_tready is low meanwhile; a finished
// result sits in an output register so the next pixel can start while it waits to be taken.
// configuration is written through a plain write port and should only change while the unit
// is idle
module mandelbrot_escape_time #(
    parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
    parameter int ITER_BITS  = mbe_pkg::ITER_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // configuration write port
    input  logic                                          i_cfg_we,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]                 i_cfg_idx,
    input  logic [mbe_pkg::WORD_W-1:0]                    i_cfg_data,
    // pixel stream in
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // col, row
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]             s_axis_tdata,
    // result stream out
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // iterations, escaped, final_mag_sq
    output logic [((ITER_BITS+mbe_pkg::WORD_W+8)/8)*8-1:0] m_axis_tdata
);
    import mbe_pkg::*;

    localparam int OUT_W = ((ITER_BITS + WORD_W + 8) / 8) * 8;

    // configuration registers
    logic signed [WORD_W-1:0]  r_x_origin, r_y_origin;
    logic [STEP_W-1:0]         r_x_step, r_y_step;
    logic [LIMIT_W-1:0]        r_max_iter;

    // output register
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_data;

    logic                      core_ready;
    logic                      core_valid;
    logic                      res_ready;
    logic                      start;
    logic [ITER_BITS-1:0]      iterations;
    logic                      escaped;
    logic [WORD_W-1:0]         final_mag_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= '0;
            r_y_origin <= '0;
            r_x_step   <= '0;
            r_y_step   <= '0;
            r_max_iter <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X_ORIGIN: r_x_origin <= i_cfg_data;
                REG_Y_ORIGIN: r_y_origin <= i_cfg_data;
                REG_X_STEP:   r_x_step   <= i_cfg_data[STEP_W-1:0];
                REG_Y_STEP:   r_y_step   <= i_cfg_data[STEP_W-1:0];
                REG_MAX_ITER: r_max_iter <= i_cfg_data[LIMIT_W-1:0];
                default: ;  // unknown index, write ignored
            endcase
        end
    end

    // a new pixel is taken only while the sequencer is idle
    assign s_axis_tready = core_ready;
    assign start         = s_axis_tvalid & core_ready;

    // result may move on when the output register is empty or being drained
    assign res_ready = !r_out_valid || m_axis_tready;

    mbe_core #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS),
        .ITER_BITS  (ITER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_col          (s_axis_tdata[COORD_BITS-1:0]),
        .i_row          (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_x_origin     (r_x_origin),
        .i_y_origin     (r_y_origin),
        .i_x_step       (r_x_step),
        .i_y_step       (r_y_step),
        .i_max_iter     (r_max_iter),
        .i_res_ready    (res_ready),
        .o_ready        (core_ready),
        .o_res_valid    (core_valid),
        .o_iterations   (iterations),
        .o_escaped      (escaped),
        .o_final_mag_sq (final_mag_sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (core_valid && res_ready) begin
            r_out_data <= OUT_W'({final_mag_sq, escaped, iterations});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
